// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent holds whenever the antecedent does
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types and constants shared by the sparse triplet transpose block.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int MAX_TERMS_DEF  = 64;
    localparam int MAX_DIM_DEF    = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ROW_W  = 8;
    localparam int COL_W  = 8;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 9;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT,
        S_PFX,
        S_SC_RD,
        S_SC_COL,
        S_SC_WR,
        S_EM_RD,
        S_EM_LD
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic cnt_upd;
        logic pfx_step;
        logic sc_rd;
        logic sc_col;
        logic sc_wr;
        logic em_rd;
        logic em_load;
    } dp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic keep;
        logic last_q;
        logic sweep_end;
        logic pfx_end;
        logic idx_last;
        logic loaded_zero;
        logic out_free;
    } dp_stat_t;

endpackage

// File: sv/sparse_triplet_transpose_top.sv
// ----------------------------------------------------------------------------
// sparse_triplet_transpose_top
// Transpose of a sparse matrix given as (row, column, value) items.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake              Fields
//  term     in   term_valid/term_stall  term_row term_col term_value term_last
//  result   out  res_valid/res_stall    out_row out_col out_value out_last
//  config   in   APB psel/penable       paddr pwdata prdata (pready tied high)
//
//  Load: each kept item adds a count store read-modify-write step. After the
//  last item: prefix sweep over the count store, scatter of each kept term,
//  then emission of each result, held while res_stall holds the output. Reset
//  starts a clearing pass of the count store; term_stall stays high through
//  it. Counts are re-cleared by the prefix sweep. A held result does not
//  block loading of the next matrix.
// ----------------------------------------------------------------------------
module sparse_triplet_transpose_top #(
    parameter int MAX_TERMS  = stt_pkg::MAX_TERMS_DEF,
    parameter int MAX_DIM    = stt_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = stt_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stt_pkg::APB_AW-1:0]        paddr,
    input  logic [stt_pkg::APB_DW-1:0]        pwdata,
    output logic [stt_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              term_valid,
    output logic                              term_stall,
    input  logic [stt_pkg::ROW_W-1:0]         term_row,
    input  logic [stt_pkg::COL_W-1:0]         term_col,
    input  logic signed [stt_pkg::VAL_W-1:0]  term_value,
    input  logic                              term_last,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [stt_pkg::COL_W-1:0]         out_row,
    output logic [stt_pkg::ROW_W-1:0]         out_col,
    output logic signed [stt_pkg::VAL_W-1:0]  out_value,
    output logic                              out_last
);

    import stt_pkg::*;

    logic [CFG_W-1:0] num_rows_reg, num_rows_next;
    logic [CFG_W-1:0] num_cols_reg, num_cols_next;
    logic             reg_idx;
    logic             cfg_wr;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        prdata        = '0;
        case (reg_idx)
            REG_NUM_ROWS:
            begin
                prdata = APB_DW'(num_rows_reg);
                if (cfg_wr)
                begin
                    num_rows_next = pwdata[CFG_W-1:0];
                end
            end
            REG_NUM_COLS:
            begin
                prdata = APB_DW'(num_cols_reg);
                if (cfg_wr)
                begin
                    num_cols_next = pwdata[CFG_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CFG_W'(1);
            num_cols_reg <= CFG_W'(1);
        end
        else
        begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
        end
    end

    stt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .stat       (stat),
        .cmd        (cmd),
        .term_stall (term_stall)
    );

    stt_dp #(
        .MAX_TERMS  (MAX_TERMS),
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .num_cols   (num_cols_reg),
        .term_valid (term_valid),
        .term_row   (term_row),
        .term_col   (term_col),
        .term_value (term_value),
        .term_last  (term_last),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .out_last   (out_last)
    );

endmodule

// File: sv/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer: count-store clear, term load, prefix sum, scatter and emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  stt_pkg::dp_stat_t stat,
    output stt_pkg::dp_cmd_t  cmd,
    output logic              term_stall
);

    import stt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    if (stat.keep)
                    begin
                        state_next = S_CNT;
                    end
                    else if (stat.in_last)
                    begin
                        state_next = S_PFX;
                    end
                end
            end
            S_CNT:
            begin
                state_next = stat.last_q ? S_PFX : S_IDLE;
            end
            S_PFX:
            begin
                if (stat.pfx_end)
                begin
                    state_next = stat.loaded_zero ? S_IDLE : S_SC_RD;
                end
            end
            S_SC_RD:
            begin
                state_next = S_SC_COL;
            end
            S_SC_COL:
            begin
                state_next = S_SC_WR;
            end
            S_SC_WR:
            begin
                state_next = stat.idx_last ? S_EM_RD : S_SC_RD;
            end
            S_EM_RD:
            begin
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.idx_last ? S_IDLE : S_EM_RD;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.clr_step = (state_reg == S_CLEAR);
        cmd.load     = (state_reg == S_IDLE) && stat.in_valid;
        cmd.cnt_upd  = (state_reg == S_CNT);
        cmd.pfx_step = (state_reg == S_PFX);
        cmd.sc_rd    = (state_reg == S_SC_RD);
        cmd.sc_col   = (state_reg == S_SC_COL);
        cmd.sc_wr    = (state_reg == S_SC_WR);
        cmd.em_rd    = (state_reg == S_EM_RD);
        cmd.em_load  = (state_reg == S_EM_LD) && stat.out_free;
        term_stall   = (state_reg != S_IDLE);
    end

    `ASSERT_IMPLIES(a_cnt_after_load, state_reg == S_CNT, $past(state_reg) == S_IDLE, "count update without a load")
    `ASSERT_IMPLIES(a_pfx_entry, (state_reg == S_PFX) && ($past(state_reg) != S_PFX), ($past(state_reg) == S_IDLE) || ($past(state_reg) == S_CNT), "prefix pass entered outside a term load")

endmodule

// File: sv/stt_dp.sv
// ----------------------------------------------------------------------------
// stt_dp
// Datapath: term store, column counts, start positions, output buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stt_dp #(
    parameter int MAX_TERMS  = stt_pkg::MAX_TERMS_DEF,
    parameter int MAX_DIM    = stt_pkg::MAX_DIM_DEF,
    parameter int VALUE_BITS = stt_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stt_pkg::dp_cmd_t                 cmd,
    output stt_pkg::dp_stat_t                stat,
    input  logic [stt_pkg::CFG_W-1:0]        num_cols,
    input  logic                             term_valid,
    input  logic [stt_pkg::ROW_W-1:0]        term_row,
    input  logic [stt_pkg::COL_W-1:0]        term_col,
    input  logic signed [stt_pkg::VAL_W-1:0] term_value,
    input  logic                             term_last,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [stt_pkg::COL_W-1:0]        out_row,
    output logic [stt_pkg::ROW_W-1:0]        out_col,
    output logic signed [stt_pkg::VAL_W-1:0] out_value,
    output logic                             out_last
);

    import stt_pkg::*;

    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int TIDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int SW_W   = $clog2(MAX_DIM + 1);
    localparam int SV_W   = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int ENT_W  = ROW_W + COL_W + SV_W;

    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [SW_W-1:0]   sw_reg, sw_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  acc_reg, acc_next;
    logic [DIM_W-1:0]  prev_reg, prev_next;
    logic [DIM_W-1:0]  col_q_reg, col_q_next;
    logic              last_q_reg, last_q_next;
    logic              out_valid_reg, out_valid_next;
    logic [COL_W-1:0]  out_row_reg, out_row_next;
    logic [ROW_W-1:0]  out_col_reg, out_col_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;

    logic [DIM_W+COL_W-1:0] in_col_ext;
    logic [DIM_W+COL_W-1:0] sc_col_ext;
    logic [DIM_W-1:0]  in_col_addr;
    logic [DIM_W-1:0]  sc_col_addr;
    logic              keep;
    logic              sweep_end;
    logic              pfx_end;
    logic              idx_last;
    logic              out_free;

    logic [ENT_W-1:0]  term_rdata;
    logic [ENT_W-1:0]  obuf_rdata;
    logic [ENT_W-1:0]  obuf_wdata;
    logic [COL_W-1:0]  sc_col;
    logic [ROW_W-1:0]  sc_row;
    logic [SV_W-1:0]   sc_val;

    logic              cnt_we, cnt_re;
    logic [DIM_W-1:0]  cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]  cnt_wdata, count_rdata;
    logic              st_we;
    logic [DIM_W-1:0]  st_waddr;
    logic [CNT_W-1:0]  st_wdata, start_rdata;

    assign in_col_ext  = (DIM_W + COL_W)'(term_col);
    assign in_col_addr = in_col_ext[DIM_W-1:0];

    assign sc_val      = term_rdata[SV_W-1:0];
    assign sc_col      = term_rdata[SV_W +: COL_W];
    assign sc_row      = term_rdata[SV_W+COL_W +: ROW_W];
    assign sc_col_ext  = (DIM_W + COL_W)'(sc_col);
    assign sc_col_addr = sc_col_ext[DIM_W-1:0];

    assign keep      = (32'(term_col) < MAX_DIM) && ({1'b0, term_col} < num_cols)
                       && (loaded_reg < CNT_W'(MAX_TERMS));
    assign sweep_end = (sw_reg == SW_W'(MAX_DIM - 1));
    assign pfx_end   = (sw_reg == SW_W'(MAX_DIM));
    assign idx_last  = (CNT_W'(j_reg + 1'b1) == loaded_reg);
    assign out_free  = !out_valid_reg || !res_stall;

    always_comb
    begin
        stat             = '0;
        stat.in_valid    = term_valid;
        stat.in_last     = term_last;
        stat.keep        = keep;
        stat.last_q      = last_q_reg;
        stat.sweep_end   = sweep_end;
        stat.pfx_end     = pfx_end;
        stat.idx_last    = idx_last;
        stat.loaded_zero = (loaded_reg == '0);
        stat.out_free    = out_free;
    end

    stt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TERMS),
        .AW    (TIDX_W)
    ) u_term_ram (
        .clk   (clk),
        .we    (cmd.load && keep),
        .waddr (loaded_reg[TIDX_W-1:0]),
        .wdata ({term_row, term_col, term_value[SV_W-1:0]}),
        .re    (cmd.sc_rd),
        .raddr (j_reg[TIDX_W-1:0]),
        .rdata (term_rdata)
    );

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = col_q_reg;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = in_col_addr;
        if (cmd.clr_step)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = sw_reg[DIM_W-1:0];
        end
        if (cmd.cnt_upd)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = col_q_reg;
            cnt_wdata = count_rdata + 1'b1;
        end
        if (cmd.pfx_step && pend_reg)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = prev_reg;
        end
        if (cmd.load)
        begin
            cnt_re = 1'b1;
        end
        if (cmd.pfx_step && !pfx_end)
        begin
            cnt_re    = 1'b1;
            cnt_raddr = sw_reg[DIM_W-1:0];
        end
    end

    stt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_DIM),
        .AW    (DIM_W)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (count_rdata)
    );

    assign st_we    = (cmd.pfx_step && pend_reg) || cmd.sc_wr;
    assign st_waddr = cmd.sc_wr ? sc_col_addr : prev_reg;
    assign st_wdata = cmd.sc_wr ? CNT_W'(start_rdata + 1'b1) : acc_reg;

    stt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_DIM),
        .AW    (DIM_W)
    ) u_start_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (cmd.sc_col),
        .raddr (sc_col_addr),
        .rdata (start_rdata)
    );

    assign obuf_wdata = {sc_col, sc_row, sc_val};

    stt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TERMS),
        .AW    (TIDX_W)
    ) u_obuf_ram (
        .clk   (clk),
        .we    (cmd.sc_wr),
        .waddr (start_rdata[TIDX_W-1:0]),
        .wdata (obuf_wdata),
        .re    (cmd.em_rd),
        .raddr (j_reg[TIDX_W-1:0]),
        .rdata (obuf_rdata)
    );

    always_comb
    begin
        loaded_next    = loaded_reg;
        j_next         = j_reg;
        sw_next        = sw_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        prev_next      = prev_reg;
        col_q_next     = col_q_reg;
        last_q_next    = last_q_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        if (cmd.load)
        begin
            col_q_next  = in_col_addr;
            last_q_next = term_last;
        end
        if (cmd.cnt_upd)
        begin
            loaded_next = loaded_reg + 1'b1;
        end
        if (cmd.clr_step)
        begin
            sw_next = sweep_end ? '0 : SW_W'(sw_reg + 1'b1);
        end
        if (cmd.pfx_step)
        begin
            if (pfx_end)
            begin
                sw_next   = '0;
                pend_next = 1'b0;
                acc_next  = '0;
            end
            else
            begin
                sw_next   = sw_reg + 1'b1;
                pend_next = 1'b1;
                prev_next = sw_reg[DIM_W-1:0];
                if (pend_reg)
                begin
                    acc_next = acc_reg + count_rdata;
                end
            end
        end
        if (cmd.sc_wr || cmd.em_load)
        begin
            j_next = idx_last ? '0 : CNT_W'(j_reg + 1'b1);
        end
        if (cmd.em_load)
        begin
            out_valid_next = 1'b1;
            out_row_next   = obuf_rdata[SV_W+ROW_W +: COL_W];
            out_col_next   = obuf_rdata[SV_W +: ROW_W];
            out_value_next = VAL_W'($signed(obuf_rdata[SV_W-1:0]));
            out_last_next  = idx_last;
            if (idx_last)
            begin
                loaded_next = '0;
            end
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            j_reg         <= '0;
            sw_reg        <= '0;
            pend_reg      <= 1'b0;
            acc_reg       <= '0;
            last_q_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            loaded_reg    <= loaded_next;
            j_reg         <= j_next;
            sw_reg        <= sw_next;
            pend_reg      <= pend_next;
            acc_reg       <= acc_next;
            last_q_reg    <= last_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        col_q_reg     <= col_q_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign res_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    `ASSERT_IMPLIES(a_scatter_pos, cmd.sc_wr, start_rdata < loaded_reg, "scatter slot past kept terms")
    `ASSERT_IMPLIES(a_count_bound, cmd.cnt_upd, count_rdata <= loaded_reg, "column count exceeds kept terms")

endmodule
